// ===== design/srpg_pkg.sv =====
// ----------------------------------------------------------------------------
// srpg_pkg: shared definitions for the stepper ramp pulse generator
// Field widths, reset values, operation and register codes, controller
// states and the command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package srpg_pkg;

  // Fixed field widths
  localparam int RPM_W      = 20;
  localparam int NUMER_W    = 25;
  localparam int PERIOD_W   = 16;
  localparam int CFG_DATA_W = 25;
  localparam int CFG_IDX_W  = 2;
  localparam int OP_W       = 2;

  // Defaults for the top-level parameters
  localparam int COUNT_WIDTH_DEF     = 24;
  localparam int PERIOD_MAX_DEF      = 65535;
  localparam int SPEED_FRAC_BITS_DEF = 16;

  // Derived divider widths at the default parameter values
  localparam int DIV_DVD_W_DEF = NUMER_W + SPEED_FRAC_BITS_DEF;
  localparam int DIV_DVS_W_DEF = (SPEED_FRAC_BITS_DEF + 12 > COUNT_WIDTH_DEF) ?
                                 SPEED_FRAC_BITS_DEF + 12 : COUNT_WIDTH_DEF;

  // Register reset values
  localparam logic [RPM_W-1:0]    MIN_RPM_RST  = RPM_W'(2560);
  localparam logic [RPM_W-1:0]    MAX_RPM_RST  = RPM_W'(153600);
  localparam logic [NUMER_W-1:0]  NUMER_RST    = NUMER_W'(150000);
  localparam logic [PERIOD_W-1:0] MIN_PER_RST  = PERIOD_W'(1);
  localparam logic [PERIOD_W-1:0] RELOAD_RST   = {PERIOD_W{1'b1}};
  localparam logic [PERIOD_W-1:0] CONST_FLOOR  = PERIOD_W'(50);

  typedef enum logic [OP_W-1:0] {
    OP_TICK  = 2'd0,
    OP_RAMP  = 2'd1,
    OP_CONST = 2'd2,
    OP_STOP  = 2'd3
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_RPM    = 2'd0,
    CFG_MAX_RPM    = 2'd1,
    CFG_NUMERATOR  = 2'd2,
    CFG_MIN_PERIOD = 2'd3
  } cfg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RAMP,
    S_SLOPE,
    S_SLOPE_WAIT,
    S_PER_GO,
    S_PER_WAIT,
    S_PUBLISH
  } ctrl_state_t;

  typedef struct packed {
    logic tick_count;
    logic tick_clear;
    logic move_halt;
    logic start_ramp;
    logic start_const;
    logic ramp_apply;
    logic slope_zero;
    logic slope_load;
    logic div_start;
    logic div_sel_period;
    logic reload_load;
    logic const_floor;
    logic step_advance;
    logic publish;
  } srpg_cmd_t;

  typedef struct packed {
    logic moving;
    logic step_level;
    logic tick_hit;
    logic steps_zero;
    logic slope_ok;
    logic div_done;
    logic out_free;
  } srpg_status_t;

endpackage

// ===== design/srpg_div.sv =====
// ----------------------------------------------------------------------------
// srpg_div: iterative restoring divider
// Produces one quotient bit per cycle; shared between the ramp slope and the
// half-period calculations.
// ----------------------------------------------------------------------------
module srpg_div #(
  parameter int DVD_W = srpg_pkg::DIV_DVD_W_DEF,
  parameter int DVS_W = srpg_pkg::DIV_DVS_W_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             done,
  output logic [DVD_W-1:0] quotient
);
  import srpg_pkg::*;

  localparam int CNT_W = (DVD_W > 1) ? $clog2(DVD_W) : 1;

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DVD_W-1:0] quo_r;
  logic [DVS_W-1:0] rem_r;
  logic [DVS_W-1:0] dvs_r;

  logic [DVS_W:0]   shifted;
  logic [DVS_W+1:0] diff;
  logic             fits;

  assign shifted = {rem_r, quo_r[DVD_W-1]};
  assign diff    = {1'b0, shifted} - {2'b00, dvs_r};
  assign fits    = ~diff[DVS_W+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(DVD_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[DVD_W-2:0], fits};
      rem_r <= fits ? diff[DVS_W-1:0] : shifted[DVS_W-1:0];
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// ===== design/srpg_ctrl.sv =====
// ----------------------------------------------------------------------------
// srpg_ctrl: sequencing controller
// Decodes each request and steps the datapath through start, ramp and
// division phases before handing the result to the output register.
// ----------------------------------------------------------------------------
module srpg_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  input  srpg_pkg::op_t          in_op,
  output logic                   in_stall,
  input  srpg_pkg::srpg_status_t status,
  output srpg_pkg::srpg_cmd_t    cmd
);
  import srpg_pkg::*;

  ctrl_state_t state_r, state_nxt;
  op_t         op_r, op_nxt;
  logic        accept;

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && (state_r == S_IDLE);
  assign op_nxt   = accept ? in_op : op_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      op_r    <= OP_TICK;
    end else begin
      state_r <= state_nxt;
      op_r    <= op_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          unique case (in_op)
            OP_TICK: begin
              if (status.moving && status.tick_hit && !status.steps_zero) begin
                state_nxt = S_RAMP;
              end else begin
                state_nxt = S_PUBLISH;
              end
            end
            OP_RAMP:  state_nxt = S_SLOPE;
            OP_CONST: state_nxt = S_PER_GO;
            OP_STOP:  state_nxt = S_PUBLISH;
            default:  state_nxt = S_PUBLISH;
          endcase
        end
      end
      S_RAMP:  state_nxt = S_PER_GO;
      S_SLOPE: state_nxt = status.slope_ok ? S_SLOPE_WAIT : S_PER_GO;
      S_SLOPE_WAIT: begin
        if (status.div_done) begin
          state_nxt = S_PER_GO;
        end
      end
      S_PER_GO: state_nxt = S_PER_WAIT;
      S_PER_WAIT: begin
        if (status.div_done) begin
          state_nxt = S_PUBLISH;
        end
      end
      S_PUBLISH: begin
        if (status.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd = '0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          unique case (in_op)
            OP_TICK: begin
              if (status.moving) begin
                if (!status.tick_hit) begin
                  cmd.tick_count = 1'b1;
                end else begin
                  cmd.tick_clear = 1'b1;
                  cmd.move_halt  = status.steps_zero;
                end
              end
            end
            OP_RAMP:  cmd.start_ramp  = 1'b1;
            OP_CONST: cmd.start_const = 1'b1;
            OP_STOP:  cmd.move_halt   = 1'b1;
            default:  cmd.move_halt   = 1'b0;
          endcase
        end
      end
      S_RAMP: cmd.ramp_apply = ~status.step_level;
      S_SLOPE: begin
        cmd.div_start  = status.slope_ok;
        cmd.slope_zero = ~status.slope_ok;
      end
      S_SLOPE_WAIT: cmd.slope_load = status.div_done;
      S_PER_GO: begin
        cmd.div_start      = 1'b1;
        cmd.div_sel_period = 1'b1;
      end
      S_PER_WAIT: begin
        cmd.reload_load  = status.div_done;
        cmd.const_floor  = (op_r == OP_CONST);
        cmd.step_advance = status.div_done && (op_r == OP_TICK);
      end
      S_PUBLISH: cmd.publish = status.out_free;
      default:   cmd = '0;
    endcase
  end

endmodule

// ===== design/srpg_datapath.sv =====
// ----------------------------------------------------------------------------
// srpg_datapath: move state, configuration and result register
// Holds the step, speed and timer state, applies the ramp, forms the
// divider operands and the clamped half-period, and registers each result.
// ----------------------------------------------------------------------------
module srpg_datapath #(
  parameter int COUNT_WIDTH     = srpg_pkg::COUNT_WIDTH_DEF,
  parameter int PERIOD_MAX      = srpg_pkg::PERIOD_MAX_DEF,
  parameter int SPEED_FRAC_BITS = srpg_pkg::SPEED_FRAC_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic [COUNT_WIDTH-1:0]          in_step_count,
  input  logic                            in_direction,
  input  logic [srpg_pkg::RPM_W-1:0]      in_target_rpm,
  input  logic                            cfg_wr,
  input  logic [srpg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [srpg_pkg::CFG_DATA_W-1:0] cfg_data,
  input  srpg_pkg::srpg_cmd_t             cmd,
  output srpg_pkg::srpg_status_t          status,
  input  logic                            out_stall,
  output logic                            out_valid,
  output logic                            out_step_out,
  output logic                            out_direction_out,
  output logic                            out_busy_res,
  output logic [COUNT_WIDTH-1:0]          out_steps_left,
  output logic [srpg_pkg::PERIOD_W-1:0]   out_period_now
);
  import srpg_pkg::*;

  localparam int SPEED_W    = SPEED_FRAC_BITS + 12;
  localparam int UNIT_SHIFT = SPEED_FRAC_BITS - 8;
  localparam int DVD_W      = NUMER_W + SPEED_FRAC_BITS;
  localparam int DVS_W      = (SPEED_W > COUNT_WIDTH) ? SPEED_W : COUNT_WIDTH;

  // Configuration
  logic [RPM_W-1:0]    min_rpm_r, max_rpm_r;
  logic [NUMER_W-1:0]  numer_r;
  logic [PERIOD_W-1:0] min_period_r;

  // Move state
  logic                   step_level_r, step_level_nxt;
  logic                   dir_level_r, dir_level_nxt;
  logic                   moving_r, moving_nxt;
  logic [COUNT_WIDTH-1:0] remaining_r, remaining_nxt;
  logic [COUNT_WIDTH-1:0] accel_r, accel_nxt;
  logic [COUNT_WIDTH-1:0] decel_r, decel_nxt;
  logic [SPEED_W-1:0]     speed_r, speed_nxt;
  logic [SPEED_W-1:0]     slope_r, slope_nxt;
  logic [PERIOD_W-1:0]    reload_r, reload_nxt;
  logic [PERIOD_W-1:0]    counter_r, counter_nxt;
  logic [RPM_W-1:0]       target_r, target_nxt;

  // Result register
  logic                   out_valid_r;
  logic                   out_step_r, out_dir_r, out_busy_r;
  logic [COUNT_WIDTH-1:0] out_steps_r;
  logic [PERIOD_W-1:0]    out_period_r;

  logic [SPEED_W-1:0]     min_s, tgt_s, const_s, ramp_speed;
  logic [SPEED_W:0]       speed_sum, floor_plus_slope;
  logic [RPM_W-1:0]       rpm_hi_clamped, rpm_clamped;
  logic [COUNT_WIDTH+1:0] triple_steps;
  logic [DVD_W-1:0]       div_dividend, div_quo, hp_wide;
  logic [DVS_W-1:0]       div_divisor;
  logic                   div_done;
  logic [PERIOD_W-1:0]    hp_floor, hp_reload;

  assign min_s = SPEED_W'(min_rpm_r) << UNIT_SHIFT;
  assign tgt_s = SPEED_W'(target_r) << UNIT_SHIFT;

  // Constant-speed target, clamped with the lower bound taking precedence
  assign rpm_hi_clamped = (in_target_rpm > max_rpm_r) ? max_rpm_r : in_target_rpm;
  assign rpm_clamped    = (rpm_hi_clamped < min_rpm_r) ? min_rpm_r : rpm_hi_clamped;
  assign const_s        = SPEED_W'(rpm_clamped) << UNIT_SHIFT;

  assign triple_steps = {2'b00, in_step_count} + {1'b0, in_step_count, 1'b0};

  // One ramp step: accelerate with saturation, hold, or decelerate down to min_rpm
  assign speed_sum        = {1'b0, speed_r} + {1'b0, slope_r};
  assign floor_plus_slope = {1'b0, min_s} + {1'b0, slope_r};
  always_comb begin
    ramp_speed = speed_r;
    if (remaining_r > accel_r) begin
      ramp_speed = speed_sum[SPEED_W] ? {SPEED_W{1'b1}} : speed_sum[SPEED_W-1:0];
    end else if (remaining_r < decel_r) begin
      ramp_speed = ({1'b0, speed_r} >= floor_plus_slope) ? (speed_r - slope_r) : min_s;
    end
  end

  // Divider operands
  assign div_dividend = cmd.div_sel_period ? {numer_r, {SPEED_FRAC_BITS{1'b0}}}
                                           : DVD_W'(tgt_s - min_s);
  assign div_divisor  = cmd.div_sel_period ? DVS_W'(speed_r) : DVS_W'(decel_r);

  srpg_div #(
    .DVD_W (DVD_W),
    .DVS_W (DVS_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quo)
  );

  // Half-period: quotient less one, raised to the floor, cut to PERIOD_MAX
  always_comb begin
    if (cmd.const_floor) begin
      hp_floor = (min_period_r < CONST_FLOOR) ? CONST_FLOOR : min_period_r;
    end else begin
      hp_floor = (min_period_r == '0) ? PERIOD_W'(1) : min_period_r;
    end
    if (speed_r == '0) begin
      hp_wide = DVD_W'(PERIOD_MAX);
    end else if (div_quo <= DVD_W'(hp_floor)) begin
      hp_wide = DVD_W'(hp_floor);
    end else begin
      hp_wide = div_quo - 1'b1;
    end
    hp_reload = (hp_wide > DVD_W'(PERIOD_MAX)) ? PERIOD_W'(PERIOD_MAX)
                                               : hp_wide[PERIOD_W-1:0];
  end

  always_comb begin
    step_level_nxt = step_level_r;
    dir_level_nxt  = dir_level_r;
    moving_nxt     = moving_r;
    remaining_nxt  = remaining_r;
    accel_nxt      = accel_r;
    decel_nxt      = decel_r;
    speed_nxt      = speed_r;
    slope_nxt      = slope_r;
    reload_nxt     = reload_r;
    counter_nxt    = counter_r;
    target_nxt     = target_r;

    if (cmd.tick_count) begin
      counter_nxt = counter_r + 1'b1;
    end
    if (cmd.tick_clear) begin
      counter_nxt = '0;
    end
    if (cmd.move_halt) begin
      moving_nxt = 1'b0;
    end
    if (cmd.start_ramp || cmd.start_const) begin
      moving_nxt    = 1'b1;
      dir_level_nxt = in_direction;
      remaining_nxt = in_step_count;
      counter_nxt   = '0;
      target_nxt    = in_target_rpm;
    end
    if (cmd.start_ramp) begin
      accel_nxt = triple_steps[COUNT_WIDTH+1:2];
      decel_nxt = in_step_count >> 2;
      speed_nxt = min_s;
    end
    if (cmd.start_const) begin
      accel_nxt = {COUNT_WIDTH{1'b1}};
      decel_nxt = '0;
      slope_nxt = '0;
      speed_nxt = const_s;
    end
    if (cmd.ramp_apply) begin
      speed_nxt = ramp_speed;
    end
    if (cmd.slope_zero) begin
      slope_nxt = '0;
    end
    if (cmd.slope_load) begin
      slope_nxt = div_quo[SPEED_W-1:0];
    end
    if (cmd.reload_load) begin
      reload_nxt = hp_reload;
    end
    if (cmd.step_advance) begin
      step_level_nxt = ~step_level_r;
      if (!step_level_r) begin
        remaining_nxt = remaining_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_level_r <= 1'b0;
      dir_level_r  <= 1'b0;
      moving_r     <= 1'b0;
      remaining_r  <= '0;
      accel_r      <= '0;
      decel_r      <= '0;
      speed_r      <= '0;
      slope_r      <= '0;
      reload_r     <= RELOAD_RST;
      counter_r    <= '0;
      target_r     <= '0;
    end else begin
      step_level_r <= step_level_nxt;
      dir_level_r  <= dir_level_nxt;
      moving_r     <= moving_nxt;
      remaining_r  <= remaining_nxt;
      accel_r      <= accel_nxt;
      decel_r      <= decel_nxt;
      speed_r      <= speed_nxt;
      slope_r      <= slope_nxt;
      reload_r     <= reload_nxt;
      counter_r    <= counter_nxt;
      target_r     <= target_nxt;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_rpm_r    <= MIN_RPM_RST;
      max_rpm_r    <= MAX_RPM_RST;
      numer_r      <= NUMER_RST;
      min_period_r <= MIN_PER_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_MIN_RPM:    min_rpm_r    <= cfg_data[RPM_W-1:0];
        CFG_MAX_RPM:    max_rpm_r    <= cfg_data[RPM_W-1:0];
        CFG_NUMERATOR:  numer_r      <= cfg_data[NUMER_W-1:0];
        CFG_MIN_PERIOD: min_period_r <= cfg_data[PERIOD_W-1:0];
        default:        min_period_r <= min_period_r;
      endcase
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.publish) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      out_step_r   <= step_level_r;
      out_dir_r    <= dir_level_r;
      out_busy_r   <= moving_r;
      out_steps_r  <= remaining_r;
      out_period_r <= reload_r;
    end
  end

  assign status.moving     = moving_r;
  assign status.step_level = step_level_r;
  assign status.tick_hit   = (counter_r >= reload_r);
  assign status.steps_zero = (remaining_r == '0);
  assign status.slope_ok   = (tgt_s > min_s) && (decel_r != '0);
  assign status.div_done   = div_done;
  assign status.out_free   = ~out_valid_r | ~out_stall;

  assign out_valid         = out_valid_r;
  assign out_step_out      = out_step_r;
  assign out_direction_out = out_dir_r;
  assign out_busy_res      = out_busy_r;
  assign out_steps_left    = out_steps_r;
  assign out_period_now    = out_period_r;

endmodule

// ===== design/stepper_ramp_pulse_generator_top.sv =====
// ----------------------------------------------------------------------------
// stepper_ramp_pulse_generator_top: step/direction generator with ramp
// Takes 1 us ticks and move requests, keeps its own half-period timer and
// produces the step line, direction line, busy flag, remaining steps and
// the current half-period reload after every request.
// ----------------------------------------------------------------------------
//
//   Channel  Handshake              Payload
//   -------  ---------------------  ------------------------------------------
//   in       in_valid / in_stall    operation, step_count, direction,
//                                   target_rpm
//   out      out_valid / out_stall  step_out, direction_out, busy_res,
//                                   steps_left, period_now
//   cfg      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// Sequencing: the block works on one request at a time. A tick that does
// not fire the timer, or a stop, goes straight to the output register. A
// constant-speed start or a tick that fires a step runs the shared
// restoring divider once, for the half-period; its dividend is D =
// 25 + SPEED_FRAC_BITS bits wide (41 by default). A ramped start runs that
// divider twice when it needs a slope, once for the slope, then the half-period.
// Reset is synchronous and active low; it restores the default
// configuration and an idle, stationary motor. A stalled result holds in
// the output register; the next request is still taken meanwhile, and the
// block only waits when a second result is ready before the first is taken.
// cfg_ready is always high: registers are written in the cycle offered.
// ----------------------------------------------------------------------------
module stepper_ramp_pulse_generator_top #(
  parameter int COUNT_WIDTH     = srpg_pkg::COUNT_WIDTH_DEF,
  parameter int PERIOD_MAX      = srpg_pkg::PERIOD_MAX_DEF,
  parameter int SPEED_FRAC_BITS = srpg_pkg::SPEED_FRAC_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // Request channel
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [srpg_pkg::OP_W-1:0]       in_operation,
  input  logic [COUNT_WIDTH-1:0]          in_step_count,
  input  logic                            in_direction,
  input  logic [srpg_pkg::RPM_W-1:0]      in_target_rpm,
  // Result channel
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_step_out,
  output logic                            out_direction_out,
  output logic                            out_busy_res,
  output logic [COUNT_WIDTH-1:0]          out_steps_left,
  output logic [srpg_pkg::PERIOD_W-1:0]   out_period_now,
  // Configuration write channel
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [srpg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [srpg_pkg::CFG_DATA_W-1:0] cfg_data
);
  import srpg_pkg::*;

  srpg_cmd_t    cmd;
  srpg_status_t status;

  // Configuration is accepted unconditionally; the user must write it only
  // while no request is in flight. The block itself does not enforce this.
  assign cfg_ready = 1'b1;

  // The controller decodes the operation and sequences the datapath.
  srpg_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_op    (op_t'(in_operation)),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // The datapath holds all move state, the configuration registers, the
  // shared divider and the output register.
  srpg_datapath #(
    .COUNT_WIDTH     (COUNT_WIDTH),
    .PERIOD_MAX      (PERIOD_MAX),
    .SPEED_FRAC_BITS (SPEED_FRAC_BITS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_step_count     (in_step_count),
    .in_direction      (in_direction),
    .in_target_rpm     (in_target_rpm),
    .cfg_wr            (cfg_valid && cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .cmd               (cmd),
    .status            (status),
    .out_stall         (out_stall),
    .out_valid         (out_valid),
    .out_step_out      (out_step_out),
    .out_direction_out (out_direction_out),
    .out_busy_res      (out_busy_res),
    .out_steps_left    (out_steps_left),
    .out_period_now    (out_period_now)
  );

  // A request once taken closes the input in the next cycle.
  a_one_request: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("second request accepted while one is in progress");

  // A new result is only written into a free output register.
  a_publish_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.publish |-> (!out_valid || !out_stall))
    else $error("result overwrote one still waiting");

  // A published half-period is never zero.
  a_period_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_period_now != '0))
    else $error("zero half-period reported");

  // Start, ramp, reload and divider start commands never coincide.
  a_exclusive_cmds: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.start_ramp, cmd.start_const, cmd.ramp_apply, cmd.reload_load,
              cmd.div_start}))
    else $error("conflicting datapath commands");

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the stepper ramp pulse generator
// Drives ticks, ramped and constant-speed move starts and stops into the
// block under random sender gaps and receiver stalls, predicts the status
// after every request with its own model of the step timer and speed ramp,
// and compares each returned status with the oldest prediction.
// ----------------------------------------------------------------------------
module tb;
  import srpg_pkg::*;

  // The block is built with its default parameters, so the bench works at
  // the same widths: 24-bit step counts and 28-bit speeds with 16 fraction
  // bits (rpm in 1/256 units is shifted left by eight).
  localparam int STEP_W       = 24;
  localparam int SPEED_W      = 28;
  localparam int SPEED_FRAC   = 16;
  localparam int PERIOD_LIMIT = 65535;
  localparam logic [63:0] SPEED_FULL = (64'd1 << SPEED_W) - 64'd1;
  // A constant-speed start never reloads below this on its first half-period.
  localparam logic [PERIOD_W-1:0] FIRST_RELOAD_FLOOR = PERIOD_W'(50);
  // A ramped start runs the shared divider twice when it needs a slope; the
  // closing wait and the watchdog are sized well beyond such a start.
  localparam int DRAIN_CYCLES   = 120;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int REPORT_LIMIT   = 10;

  typedef struct packed {
    logic                step;
    logic                dir;
    logic                busy;
    logic [STEP_W-1:0]   steps_left;
    logic [PERIOD_W-1:0] period;
  } motor_status_t;

  logic clk;
  logic rst_n = 1'b0;

  logic                  in_valid      = 1'b0;
  logic                  in_stall;
  logic [OP_W-1:0]       in_operation  = OP_TICK;
  logic [STEP_W-1:0]     in_step_count = '0;
  logic                  in_direction  = 1'b0;
  logic [RPM_W-1:0]      in_target_rpm = '0;
  logic                  out_valid;
  logic                  out_stall     = 1'b0;
  logic                  out_step_out;
  logic                  out_direction_out;
  logic                  out_busy_res;
  logic [STEP_W-1:0]     out_steps_left;
  logic [PERIOD_W-1:0]   out_period_now;
  logic                  cfg_valid     = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index     = CFG_MIN_RPM;
  logic [CFG_DATA_W-1:0] cfg_data      = '0;

  stepper_ramp_pulse_generator_top u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_operation      (in_operation),
    .in_step_count     (in_step_count),
    .in_direction      (in_direction),
    .in_target_rpm     (in_target_rpm),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_step_out      (out_step_out),
    .out_direction_out (out_direction_out),
    .out_busy_res      (out_busy_res),
    .out_steps_left    (out_steps_left),
    .out_period_now    (out_period_now),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  // --------------------------------------------------------------------------
  // Predicted configuration and motor state. These start at the values the
  // block comes out of reset with, and are only touched when a request or a
  // register write is actually accepted.
  // --------------------------------------------------------------------------
  logic [RPM_W-1:0]    gen_min_rpm    = RPM_W'(2560);
  logic [RPM_W-1:0]    gen_max_rpm    = RPM_W'(153600);
  logic [NUMER_W-1:0]  gen_numerator  = NUMER_W'(150000);
  logic [PERIOD_W-1:0] gen_min_period = PERIOD_W'(1);

  logic                gen_step_lvl   = 1'b0;
  logic                gen_dir_lvl    = 1'b0;
  logic                gen_busy       = 1'b0;
  logic [STEP_W-1:0]   gen_steps_left = '0;
  logic [STEP_W-1:0]   gen_accel_edge = '0;
  logic [STEP_W-1:0]   gen_decel_edge = '0;
  logic [SPEED_W-1:0]  gen_speed      = '0;
  logic [SPEED_W-1:0]  gen_slope      = '0;
  logic [PERIOD_W-1:0] gen_reload     = '1;
  logic [PERIOD_W-1:0] gen_tick_count = '0;

  motor_status_t expected_status_q[$];

  int fail_count    = 0;
  int results_seen  = 0;
  int requests_sent = 0;
  int burst_left    = 0;
  // Mirrors the value most recently scheduled onto in_valid, so that the
  // valid line is never scheduled twice in the same time step.
  bit valid_drv     = 1'b0;

  // Clock: 20 ns period.
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------

  // Half-period reload for a speed: the numerator over the speed, less one,
  // held at or above the floor (a floor of zero counts as one) and cut to
  // sixteen bits. A standing motor gets the longest reload.
  function automatic logic [PERIOD_W-1:0] reload_for_speed(logic [SPEED_W-1:0] spd,
                                                           logic [PERIOD_W-1:0] floor_in);
    logic [63:0] lim;
    logic [63:0] quot;
    logic [63:0] res;
    lim = (floor_in == '0) ? 64'd1 : 64'(floor_in);
    if (spd == '0) begin
      res = 64'(PERIOD_LIMIT);
    end else begin
      quot = (64'(gen_numerator) << SPEED_FRAC) / 64'(spd);
      res  = (quot <= lim) ? lim : quot - 64'd1;
    end
    if (res > 64'(PERIOD_LIMIT)) begin
      res = 64'(PERIOD_LIMIT);
    end
    return res[PERIOD_W-1:0];
  endfunction

  // One expiry of the half-period timer. The speed only moves on the update
  // that raises the step line, judged on the step count before it drops.
  function automatic void fire_step_timer();
    logic [63:0] floor_s;
    logic [63:0] sum;
    if (gen_steps_left == '0 || !gen_busy) begin
      gen_busy = 1'b0;
      return;
    end
    if (!gen_step_lvl) begin
      floor_s = 64'({gen_min_rpm, 8'h00});
      if (gen_steps_left > gen_accel_edge) begin
        sum       = 64'(gen_speed) + 64'(gen_slope);
        gen_speed = (sum > SPEED_FULL) ? SPEED_FULL[SPEED_W-1:0] : sum[SPEED_W-1:0];
      end else if (gen_steps_left < gen_decel_edge) begin
        if (64'(gen_speed) >= floor_s + 64'(gen_slope)) begin
          gen_speed = gen_speed - gen_slope;
        end else begin
          gen_speed = floor_s[SPEED_W-1:0];
        end
      end
    end
    gen_reload   = reload_for_speed(gen_speed, gen_min_period);
    gen_step_lvl = !gen_step_lvl;
    if (gen_step_lvl) begin
      gen_steps_left = gen_steps_left - 1'b1;
    end
  endfunction

  function automatic void begin_move(logic [STEP_W-1:0] steps, logic dir);
    gen_busy       = 1'b1;
    gen_dir_lvl    = dir;
    gen_steps_left = steps;
    gen_tick_count = '0;
  endfunction

  // Applies one accepted request and queues the status it should produce.
  function automatic void predict_request(op_t op, logic [STEP_W-1:0] steps, logic dir,
                                          logic [RPM_W-1:0] rpm);
    logic [SPEED_W-1:0]  min_s;
    logic [SPEED_W-1:0]  tgt_s;
    logic [63:0]         prod;
    logic [RPM_W-1:0]    cruise;
    logic [PERIOD_W-1:0] first_floor;
    case (op)
      OP_TICK: begin
        if (gen_busy) begin
          if (gen_tick_count >= gen_reload) begin
            gen_tick_count = '0;
            fire_step_timer();
          end else begin
            gen_tick_count = gen_tick_count + 1'b1;
          end
        end
      end
      OP_RAMP: begin
        min_s = {gen_min_rpm, 8'h00};
        tgt_s = {rpm, 8'h00};
        begin_move(steps, dir);
        prod           = 64'(gen_steps_left) * 64'd3;
        gen_accel_edge = prod[STEP_W+1:2];
        gen_decel_edge = gen_steps_left >> 2;
        if (tgt_s > min_s && gen_decel_edge != '0) begin
          gen_slope = SPEED_W'((tgt_s - min_s) / gen_decel_edge);
        end else begin
          gen_slope = '0;
        end
        gen_speed  = min_s;
        gen_reload = reload_for_speed(gen_speed, gen_min_period);
      end
      OP_CONST: begin
        // The floor wins when the floor and ceiling cross.
        cruise = rpm;
        if (cruise > gen_max_rpm) begin
          cruise = gen_max_rpm;
        end
        if (cruise < gen_min_rpm) begin
          cruise = gen_min_rpm;
        end
        begin_move(steps, dir);
        gen_accel_edge = '1;
        gen_decel_edge = '0;
        gen_slope      = '0;
        gen_speed      = {cruise, 8'h00};
        first_floor    = (gen_min_period < FIRST_RELOAD_FLOOR) ? FIRST_RELOAD_FLOOR
                                                               : gen_min_period;
        gen_reload     = reload_for_speed(gen_speed, first_floor);
      end
      default: begin
        // Stop keeps the counts, levels and reload as they are.
        gen_busy = 1'b0;
      end
    endcase
    expected_status_q.push_back({gen_step_lvl, gen_dir_lvl, gen_busy, gen_steps_left,
                                 gen_reload});
  endfunction

  function automatic void store_setting(cfg_idx_t idx, logic [CFG_DATA_W-1:0] value);
    case (idx)
      CFG_MIN_RPM:   gen_min_rpm    = value[RPM_W-1:0];
      CFG_MAX_RPM:   gen_max_rpm    = value[RPM_W-1:0];
      CFG_NUMERATOR: gen_numerator  = value[NUMER_W-1:0];
      default:       gen_min_period = value[PERIOD_W-1:0];
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Checking
  // --------------------------------------------------------------------------
  function automatic string status_text(motor_status_t s);
    return $sformatf("step %0b dir %0b busy %0b steps_left %0d period %0d",
                     s.step, s.dir, s.busy, s.steps_left, s.period);
  endfunction

  // Every failure is counted; only the first few are described.
  function automatic void report_failure(string msg);
    fail_count++;
    if (fail_count <= REPORT_LIMIT) begin
      $display("ERROR: %s", msg);
    end
  endfunction

  // A status is taken on any edge where it is offered and not stalled; it
  // must match the oldest prediction still waiting.
  always @(posedge clk) begin : result_checker
    motor_status_t seen;
    motor_status_t want;
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      seen = {out_step_out, out_direction_out, out_busy_res, out_steps_left, out_period_now};
      if (expected_status_q.size() == 0) begin
        report_failure({"status with no request outstanding: ", status_text(seen)});
      end else begin
        want = expected_status_q.pop_front();
        if (seen !== want) begin
          report_failure($sformatf("status %0d: expected %s, got %s", results_seen,
                                   status_text(want), status_text(seen)));
        end
      end
      results_seen++;
    end
  end

  // The receiver cycles through stretches of its own: no stalls at all,
  // light random stalls, heavy random stalls and long stall runs.
  initial begin : result_stall_pattern
    int mode;
    int span;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(10, 80);
      repeat (span) begin
        @(posedge clk);
        case (mode)
          0:       out_stall <= 1'b0;
          1:       out_stall <= ($urandom_range(0, 3) == 0);
          2:       out_stall <= ($urandom_range(0, 1) == 0);
          default: out_stall <= ($urandom_range(0, 7) == 0) ? !out_stall : out_stall;
        endcase
      end
    end
  end

  // The run is abandoned if no channel moves anything for too long.
  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall) ||
          (cfg_valid && cfg_ready === 1'b1)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("Some tests failed");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  // Offers one request and holds it until the block takes it. The sender
  // works in bursts; at the end of each burst valid drops for a random gap.
  // Within a burst valid stays high into the next request.
  task automatic send_request(op_t op, logic [STEP_W-1:0] steps, logic dir,
                              logic [RPM_W-1:0] rpm);
    int gap;
    valid_drv = 1'b1;
    in_valid      <= 1'b1;
    in_operation  <= op;
    in_step_count <= steps;
    in_direction  <= dir;
    in_target_rpm <= rpm;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    predict_request(op, steps, dir, rpm);
    requests_sent++;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(0, 15);
      gap       = $urandom_range(1, 12);
      valid_drv = 1'b0;
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end else begin
      burst_left--;
    end
  endtask

  // Ticks carry random payload, which the block must ignore.
  task automatic send_tick();
    send_request(OP_TICK, STEP_W'($urandom), 1'($urandom_range(0, 1)), RPM_W'($urandom));
  endtask

  task automatic tick_until_idle(int cap);
    int n;
    n = 0;
    while (gen_busy && n < cap) begin
      send_tick();
      n++;
    end
  endtask

  // Stops offering requests and waits for every outstanding status.
  task automatic wait_for_idle();
    if (valid_drv) begin
      valid_drv = 1'b0;
      in_valid <= 1'b0;
    end
    while (expected_status_q.size() != 0) @(posedge clk);
  endtask

  // Writes all four registers back to back once the block has gone quiet.
  task automatic load_settings(logic [CFG_DATA_W-1:0] min_rpm_v, logic [CFG_DATA_W-1:0] max_rpm_v,
                               logic [CFG_DATA_W-1:0] numer_v, logic [CFG_DATA_W-1:0] min_per_v);
    cfg_idx_t              reg_order [4];
    logic [CFG_DATA_W-1:0] reg_value [4];
    reg_order = '{CFG_MIN_RPM, CFG_MAX_RPM, CFG_NUMERATOR, CFG_MIN_PERIOD};
    reg_value = '{min_rpm_v, max_rpm_v, numer_v, min_per_v};
    wait_for_idle();
    for (int i = 0; i < 4; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= reg_order[i];
      cfg_data  <= reg_value[i];
      @(posedge clk);
      while (cfg_ready !== 1'b1) @(posedge clk);
      store_setting(reg_order[i], reg_value[i]);
    end
    cfg_valid <= 1'b0;
  endtask

  // Settings that keep half-periods to a handful of ticks: a start speed of
  // two to six rpm against a small numerator. The ceiling sometimes falls
  // below the floor.
  task automatic pick_fast_settings();
    load_settings($urandom_range(512, 1536), $urandom_range(256, 8192),
                  $urandom_range(2, 12), $urandom_range(0, 3));
  endtask

  function automatic logic [STEP_W-1:0] pick_move_length();
    return ($urandom_range(0, 7) == 0) ? STEP_W'($urandom_range(11, 40))
                                       : STEP_W'($urandom_range(0, 10));
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Idle behaviour, the field extremes, clamping of the cruise speed, zero
  // speed and a zero half-period floor.
  task automatic test_idle_and_extremes();
    send_request(OP_TICK, '1, 1'b1, '1);           // tick while idle changes nothing
    send_request(OP_STOP, '0, 1'b0, '0);
    send_request(OP_RAMP, '0, 1'b1, '0);           // zero steps, reset settings
    send_request(OP_TICK, '0, 1'b0, '0);
    send_request(OP_STOP, '0, 1'b1, '0);
    // Ten rpm against a numerator of 20 gives a reload of one tick.
    load_settings(2560, 153600, 20, 1);
    send_request(OP_RAMP, '0, 1'b0, RPM_W'(5120));  // busy until the first update
    send_tick();
    send_tick();
    send_request(OP_CONST, '1, 1'b0, '1);          // above the ceiling
    send_request(OP_STOP, '0, 1'b0, '0);
    send_request(OP_CONST, STEP_W'(3), 1'b1, '0);  // below the floor
    send_request(OP_RAMP, '1, 1'b1, '1);           // restart over a running move
    send_request(OP_STOP, '1, 1'b1, '1);
    // Floor above ceiling, largest numerator and largest reload floor.
    load_settings(20'hFFFFF, 1, 25'h1FFFFFF, 16'hFFFF);
    send_request(OP_CONST, STEP_W'(5), 1'b0, RPM_W'(500));
    send_request(OP_RAMP, STEP_W'(9), 1'b1, RPM_W'(20'h80000));
    send_request(OP_STOP, '0, 1'b0, '0);
    // A start speed of zero, and a reload floor of zero that acts as one.
    load_settings(0, 20'hFFFFF, 1, 0);
    send_request(OP_RAMP, STEP_W'(8), 1'b0, RPM_W'(1000));
    send_request(OP_TICK, '0, 1'b1, '1);
    send_request(OP_CONST, STEP_W'(8), 1'b1, '1);
    send_request(OP_STOP, '0, 1'b0, '0);
  endtask

  // Short ramps to the top speed: the acceleration quarter adds more than
  // the speed can hold, so it must saturate. A target below the start speed
  // gives a flat move.
  task automatic test_speed_saturation();
    int lengths [3];
    lengths = '{7, 11, 15};
    load_settings(64, 20'hFFFFF, 1, 0);
    foreach (lengths[i]) begin
      send_request(OP_RAMP, STEP_W'(lengths[i]), 1'(i), '1);
      tick_until_idle(400);
    end
    send_request(OP_RAMP, STEP_W'(12), 1'b0, RPM_W'(10));
    tick_until_idle(400);
    send_request(OP_CONST, STEP_W'(2), 1'b1, RPM_W'(300));
    tick_until_idle(400);
  endtask

  // Complete ramped moves, each ticked until the motor stands again.
  task automatic test_ramped_moves(int budget);
    int moves;
    moves = 0;
    while (requests_sent < budget) begin
      if (moves % 3 == 0) begin
        pick_fast_settings();
      end
      send_request(OP_RAMP, pick_move_length(), 1'($urandom_range(0, 1)),
                   RPM_W'($urandom_range(0, 8192)));
      tick_until_idle(600);
      moves++;
    end
  endtask

  // Complete constant-speed moves, including the long first half-period.
  task automatic test_constant_moves(int budget);
    int moves;
    moves = 0;
    while (requests_sent < budget) begin
      if (moves % 3 == 0) begin
        pick_fast_settings();
      end
      send_request(OP_CONST, STEP_W'($urandom_range(0, 8)), 1'($urandom_range(0, 1)),
                   RPM_W'($urandom_range(0, 8192)));
      tick_until_idle(600);
      moves++;
    end
  endtask

  // Moves cut short by a stop or by a new start, mixed with requests whose
  // every field is random, and the odd change of settings between them.
  task automatic test_interrupted_moves(int budget);
    int choice;
    while (requests_sent < budget) begin
      choice = $urandom_range(0, 9);
      if (choice <= 5) begin
        send_request(($urandom_range(0, 1) == 0) ? OP_RAMP : OP_CONST, pick_move_length(),
                     1'($urandom_range(0, 1)), RPM_W'($urandom_range(0, 8192)));
        repeat ($urandom_range(0, 60)) send_tick();
        if ($urandom_range(0, 1) == 0) begin
          send_request(OP_STOP, STEP_W'($urandom), 1'($urandom_range(0, 1)), RPM_W'($urandom));
          repeat ($urandom_range(0, 4)) send_tick();
        end
      end else if (choice <= 7) begin
        send_request(op_t'($urandom_range(0, 3)), STEP_W'($urandom), 1'($urandom_range(0, 1)),
                     RPM_W'($urandom));
      end else if (choice == 8) begin
        pick_fast_settings();
      end else begin
        tick_until_idle(600);
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Sequence: reset once, run each test in turn, then let the last statuses
  // drain and give the block time to show any stray result.
  // --------------------------------------------------------------------------
  initial begin : main_sequence
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    test_idle_and_extremes();
    test_speed_saturation();
    test_ramped_moves(700);
    test_constant_moves(1100);
    test_interrupted_moves(1850);
    wait_for_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_status_q.size() != 0) begin
      report_failure($sformatf("%0d statuses never arrived", expected_status_q.size()));
    end
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
